### rtl/thermo_pkg.sv
// thermostat package: item codes, configuration register indexes, reset values
// and the small structs passed between the thermostat modules
// no dependencies

package thermo_pkg;

   // beat kinds on the request side
   localparam logic [1:0] MODE_SAMPLE  = 2'd0;
   localparam logic [1:0] MODE_CHAR    = 2'd1;
   localparam logic [1:0] MODE_SESSION = 2'd2;

   // entry status codes
   localparam logic [1:0] STATUS_NONE   = 2'd0;
   localparam logic [1:0] STATUS_ACCEPT = 2'd1;
   localparam logic [1:0] STATUS_RANGE  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_SP_LOW        = 2'd0;
   localparam logic [1:0] CSR_SP_HIGH       = 2'd1;
   localparam logic [1:0] CSR_ALARM_OFFSET  = 2'd2;
   localparam logic [1:0] CSR_ALARM_CEILING = 2'd3;

   // configuration and state reset values
   localparam logic [6:0] SP_LOW_RST        = 7'd27;
   localparam logic [6:0] SP_HIGH_RST       = 7'd68;
   localparam logic [6:0] ALARM_OFFSET_RST  = 7'd10;
   localparam logic [6:0] ALARM_CEILING_RST = 7'd75;
   localparam logic [6:0] SETPOINT_RST      = 7'd30;
   localparam logic [6:0] ALARM_LEVEL_RST   = 7'd40;

   // converter scaling
   localparam int unsigned ADC_FULL   = 4095;
   localparam int unsigned TEMP_BASE  = 2500;
   localparam int unsigned TEMP_SPAN  = 5000;
   localparam int unsigned TEMP_MAX   = 7500;
   localparam logic [7:0]  CHAR_ZERO  = 8'h30;
   localparam logic [7:0]  CHAR_NINE  = 8'h39;
   localparam logic [7:0]  CHAR_CR    = 8'h0d;

   typedef struct packed {
      logic [6:0] sp_low;
      logic [6:0] sp_high;
      logic [6:0] alarm_offset;
      logic [6:0] alarm_ceiling;
   } cfg_type;

   typedef struct packed {
      logic heater;
      logic alarm;
   } flags_type;

   typedef struct packed {
      logic [6:0] setpoint;
      logic [6:0] alarm_level;
   } levels_type;

endpackage

### rtl/thermo_sample.sv
// sample path: converter reading to hundredths of a degree, and the
// heater and alarm hysteresis decisions; uses thermo_pkg

module thermo_sample (
   input  logic [11:0]             sample,
   input  thermo_pkg::levels_type  levels,
   input  thermo_pkg::flags_type   flags,
   output logic [12:0]             temp_centi,
   output thermo_pkg::flags_type   flags_next
);
   import thermo_pkg::*;

   logic [24:0] scaled;
   logic [12:0] quot_est;
   logic [13:0] rem_est;
   logic [12:0] quot;
   logic [19:0] twice_t;
   logic        above_sp;
   logic        below_sp;
   logic        above_al;
   logic        below_al;

   // x * 4095 as a shift and subtract
   function automatic logic [19:0] times_full(input logic [7:0] x);
      return {x, 12'b0} - {12'b0, x};
   endfunction

   // T > level + 0.5, both sides scaled by 2*4095
   function automatic logic over_band(input logic [19:0] a, input logic [6:0] level);
      return a > times_full({level, 1'b1});
   endfunction

   // T < level - 0.5
   function automatic logic under_band(input logic [19:0] a, input logic [6:0] level);
      return ({1'b0, a} + 21'(ADC_FULL)) < {1'b0, times_full({level, 1'b0})};
   endfunction

   // floor(5000*s / 4095): split at 4096 and fold the remainder back
   always_comb begin
      scaled   = 25'(sample) * 25'(TEMP_SPAN);
      quot_est = scaled[24:12];
      rem_est  = {2'b0, scaled[11:0]} + {1'b0, quot_est};
      quot     = quot_est
                 + 13'(rem_est >= 14'(ADC_FULL))
                 + 13'(rem_est >= 14'(2 * ADC_FULL));
      temp_centi = 13'(TEMP_BASE) + quot;
   end

   // twice the temperature times 4095
   assign twice_t = 20'(100 * 20'(sample)) + 20'(50 * ADC_FULL);

   assign above_sp = over_band(twice_t, levels.setpoint);
   assign below_sp = under_band(twice_t, levels.setpoint);
   assign above_al = over_band(twice_t, levels.alarm_level);
   assign below_al = under_band(twice_t, levels.alarm_level);

   // heater switches off above the band, on below it; alarm the other way round
   always_comb begin
      flags_next.heater = flags.heater ? !above_sp : below_sp;
      flags_next.alarm  = flags.alarm  ? !below_al : above_al;
   end

endmodule

### rtl/thermo_entry.sv
// serial setpoint entry: two digit registers, setpoint and alarm level
// registers, range check and alarm cap; uses thermo_pkg

module thermo_entry (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [1:0]              mode,
   input  logic [7:0]              rx_char,
   input  thermo_pkg::cfg_type     cfg,
   output thermo_pkg::levels_type  levels,
   output logic [6:0]              setpoint_next,
   output logic [1:0]              status
);
   import thermo_pkg::*;

   logic       first_valid_ff, first_valid_in;
   logic       second_valid_ff, second_valid_in;
   logic [3:0] first_digit_ff, first_digit_in;
   logic [3:0] second_digit_ff, second_digit_in;
   levels_type levels_ff, levels_in;

   logic       is_digit;
   logic [3:0] digit;
   logic [6:0] value;
   logic       in_range;
   logic [7:0] level_sum;
   logic [6:0] level_cap;

   // character decode and candidate value
   always_comb begin
      is_digit  = (rx_char >= CHAR_ZERO) && (rx_char <= CHAR_NINE);
      digit     = 4'(rx_char - CHAR_ZERO);
      value     = 7'({3'b0, first_digit_ff} * 7'd10) + {3'b0, second_digit_ff};
      in_range  = (value >= cfg.sp_low) && (value <= cfg.sp_high);
      level_sum = {1'b0, value} + {1'b0, cfg.alarm_offset};
      level_cap = (level_sum > {1'b0, cfg.alarm_ceiling}) ? cfg.alarm_ceiling
                                                          : level_sum[6:0];
   end

   // entry sequence
   always_comb begin
      first_valid_in  = first_valid_ff;
      second_valid_in = second_valid_ff;
      first_digit_in  = first_digit_ff;
      second_digit_in = second_digit_ff;
      levels_in       = levels_ff;
      status          = STATUS_NONE;
      if (step) begin
         unique case (mode)
            MODE_CHAR: begin
               priority if (!first_valid_ff) begin
                  if (is_digit) begin
                     first_digit_in = digit;
                     first_valid_in = 1'b1;
                  end
               end else if (!second_valid_ff) begin
                  if (is_digit) begin
                     second_digit_in = digit;
                     second_valid_in = 1'b1;
                  end
               end else if (rx_char == CHAR_CR) begin
                  if (in_range) begin
                     levels_in.setpoint    = value;
                     levels_in.alarm_level = level_cap;
                     status                = STATUS_ACCEPT;
                  end else begin
                     status = STATUS_RANGE;
                  end
               end else begin
                  status = STATUS_NONE;
               end
            end
            MODE_SESSION: begin
               first_valid_in  = 1'b0;
               second_valid_in = 1'b0;
            end
            default: begin
               status = STATUS_NONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_valid_ff        <= 1'b0;
         second_valid_ff       <= 1'b0;
         levels_ff.setpoint    <= SETPOINT_RST;
         levels_ff.alarm_level <= ALARM_LEVEL_RST;
      end else begin
         first_valid_ff  <= first_valid_in;
         second_valid_ff <= second_valid_in;
         levels_ff       <= levels_in;
      end
   end

   // digit payload, read only while its valid bit is set
   always_ff @(posedge clock) begin
      first_digit_ff  <= first_digit_in;
      second_digit_ff <= second_digit_in;
   end

   assign levels        = levels_ff;
   assign setpoint_next = levels_in.setpoint;

endmodule

### rtl/thermostat_with_alarm_and_setpoint_entry.sv
// thermostat with hysteresis heater control, over-temperature alarm and serial
// setpoint entry. a taken request beat lands in the input register and its result
// beat in the result register, where it waits while rsp_tready is low. throughput:
// one beat per cycle unless the result side stalls, set by the single compute stage.
// reset: synchronous, active high; clears valids, flags, digit valids, setpoint 30,
// alarm level 40 and the configuration registers to their defaults.

module thermostat_with_alarm_and_setpoint_entry (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // sample[11:0], rx_char[19:12], zero pad
   input  logic [1:0]  req_tuser,   // mode[1:0]
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // heater_on[0], alarm_on[1], temp_centi[14:2],
                                    // setpoint_now[21:15], entry_status[23:22]
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [6:0]  csr_wdata
);
   import thermo_pkg::*;

   cfg_type     cfg_ff;
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_mode_ff;
   logic [11:0] in_sample_ff;
   logic [7:0]  in_char_ff;
   logic        out_valid_ff, out_valid_in;
   logic [23:0] out_data_ff;
   flags_type   flags_ff, flags_in;
   flags_type   flags_calc;
   levels_type  levels;
   logic [6:0]  setpoint_next;
   logic [1:0]  status;
   logic [12:0] temp_calc;
   logic [12:0] temp_out;
   logic        advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sp_low        <= SP_LOW_RST;
         cfg_ff.sp_high       <= SP_HIGH_RST;
         cfg_ff.alarm_offset  <= ALARM_OFFSET_RST;
         cfg_ff.alarm_ceiling <= ALARM_CEILING_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SP_LOW:        cfg_ff.sp_low        <= csr_wdata;
            CSR_SP_HIGH:       cfg_ff.sp_high       <= csr_wdata;
            CSR_ALARM_OFFSET:  cfg_ff.alarm_offset  <= csr_wdata;
            CSR_ALARM_CEILING: cfg_ff.alarm_ceiling <= csr_wdata;
            default:           cfg_ff               <= cfg_ff;
         endcase
      end
   end

   // handshake: compute stage moves when the result register is free or draining
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_mode_ff   <= req_tuser;
         in_sample_ff <= req_tdata[11:0];
         in_char_ff   <= req_tdata[19:12];
      end
   end

   thermo_sample u_sample (
      .sample     (in_sample_ff),
      .levels     (levels),
      .flags      (flags_ff),
      .temp_centi (temp_calc),
      .flags_next (flags_calc)
   );

   thermo_entry u_entry (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .mode          (in_mode_ff),
      .rx_char       (in_char_ff),
      .cfg           (cfg_ff),
      .levels        (levels),
      .setpoint_next (setpoint_next),
      .status        (status)
   );

   // flags move only on sample beats
   assign flags_in = (advance && (in_mode_ff == MODE_SAMPLE)) ? flags_calc : flags_ff;
   assign temp_out = (in_mode_ff == MODE_SAMPLE) ? temp_calc : 13'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         flags_ff     <= flags_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= {status, setpoint_next, temp_out, flags_in.alarm, flags_in.heater};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // non-sample beats leave both flags alone
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      advance && (in_mode_ff != MODE_SAMPLE) |=> $stable(flags_ff))
      else $error("flags changed on a non-sample beat");

   // setpoint changes only when a beat passes the compute stage
   a_setpoint_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(levels.setpoint) && $stable(levels.alarm_level))
      else $error("setpoint or alarm level changed without a beat");

   // temperature field is zero or inside the converter span
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[14:2] == 13'd0) ||
                     ((rsp_tdata[14:2] >= 13'(TEMP_BASE)) &&
                      (rsp_tdata[14:2] <= 13'(TEMP_MAX))))
      else $error("temperature out of range");

   // an accepted request beat always lands in the input register
   a_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> in_valid_ff)
      else $error("request beat lost");

   // a stalled result keeps the compute stage from overwriting it
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !advance)
      else $error("result register overwritten while stalled");

endmodule

### bench/tb.sv
// self-checking bench for the thermostat with alarm and serial setpoint entry
// drives request beats and register writes, predicts every result beat, and
// compares field by field; depends on rtl/thermo_pkg.sv and the top level rtl
`timescale 1ns / 100ps

module tb;
   import thermo_pkg::*;

   // the fourth request kind has no function in the block
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned PRINT_LIMIT = 40;

   typedef struct packed {
      logic        heater;
      logic        alarm;
      logic [12:0] temp_centi;
      logic [6:0]  setpoint;
      logic [1:0]  status;
   } reading_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [11:0] raw;
      logic [7:0]  ch;
      logic        typed;
      reading_type want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = MODE_SAMPLE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = CSR_SP_LOW;
   logic [6:0]  csr_wdata = '0;

   thermostat_with_alarm_and_setpoint_entry u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // sample[11:0], rx_char[19:12], zero pad
      .req_tuser  (req_tuser),    // mode[1:0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // heater_on[0], alarm_on[1], temp_centi[14:2],
                                  // setpoint_now[21:15], entry_status[23:22]
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // predictor copy of the registers and state
   logic [6:0]  cfg_min  = SP_LOW_RST;
   logic [6:0]  cfg_max  = SP_HIGH_RST;
   logic [6:0]  cfg_off  = ALARM_OFFSET_RST;
   logic [6:0]  cfg_ceil = ALARM_CEILING_RST;
   int unsigned sp_deg    = 32'(SETPOINT_RST);
   int unsigned alarm_lvl = 32'(ALARM_LEVEL_RST);
   logic        heat_q  = 1'b0;
   logic        alarm_q = 1'b0;
   logic        hi_valid = 1'b0;
   logic        lo_valid = 1'b0;
   int unsigned dig_hi = 0;
   int unsigned dig_lo = 0;

   reading_type pending_readings [$];
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned beats_sent = 0;
   int unsigned samples_sent = 0;
   int unsigned chars_sent = 0;
   int unsigned taken_count = 0;
   int unsigned refused_count = 0;
   int unsigned settings_used = 1;
   int unsigned stall_left = 0;
   bit          idle_on = 1'b0;

   // directed rows: typed expectations where the value is obvious
   plan_row_type plan [29] = '{
      '{MODE_SAMPLE,  12'd0,    8'h00, 1'b1, '{1'b1, 1'b0, 13'd2500, 7'd30, STATUS_NONE}},
      '{MODE_SAMPLE,  12'd4095, 8'h00, 1'b1, '{1'b0, 1'b1, 13'd7500, 7'd30, STATUS_NONE}},
      '{MODE_SAMPLE,  12'd2048, 8'h00, 1'b0, '0},
      '{MODE_SAMPLE,  12'd368,  8'h00, 1'b0, '0},
      '{MODE_SAMPLE,  12'd451,  8'h00, 1'b0, '0},
      '{MODE_SESSION, 12'd0,    8'h00, 1'b1, '{1'b0, 1'b0, 13'd0, 7'd30, STATUS_NONE}},
      '{MODE_CHAR,    12'd0,    8'h2f, 1'b0, '0},
      '{MODE_CHAR,    12'd0,    8'h0d, 1'b0, '0},
      '{MODE_CHAR,    12'd0,    8'h39, 1'b0, '0},
      '{MODE_CHAR,    12'd0,    8'h3a, 1'b0, '0},
      '{MODE_CHAR,    12'd0,    8'h39, 1'b0, '0},
      '{MODE_CHAR,    12'd0,    8'h41, 1'b0, '0},
      '{MODE_CHAR,    12'd0,    8'h0d, 1'b1, '{1'b0, 1'b0, 13'd0, 7'd30, STATUS_RANGE}},
      '{MODE_SPARE,   12'hfff,  8'hff, 1'b1, '{1'b0, 1'b0, 13'd0, 7'd30, STATUS_NONE}},
      '{MODE_SESSION, 12'd0,    8'h00, 1'b0, '0},
      '{MODE_CHAR,    12'd0,    8'h30, 1'b0, '0},
      '{MODE_CHAR,    12'd0,    8'h30, 1'b0, '0},
      '{MODE_CHAR,    12'd0,    8'h0d, 1'b1, '{1'b0, 1'b0, 13'd0, 7'd30, STATUS_RANGE}},
      '{MODE_SESSION, 12'd0,    8'h00, 1'b0, '0},
      '{MODE_CHAR,    12'd0,    8'h36, 1'b0, '0},
      '{MODE_CHAR,    12'd0,    8'h38, 1'b0, '0},
      '{MODE_CHAR,    12'd0,    8'h0d, 1'b1, '{1'b0, 1'b0, 13'd0, 7'd68, STATUS_ACCEPT}},
      '{MODE_CHAR,    12'd0,    8'h0d, 1'b1, '{1'b0, 1'b0, 13'd0, 7'd68, STATUS_ACCEPT}},
      '{MODE_SAMPLE,  12'd4095, 8'h00, 1'b1, '{1'b0, 1'b0, 13'd7500, 7'd68, STATUS_NONE}},
      '{MODE_SESSION, 12'd0,    8'h00, 1'b0, '0},
      '{MODE_CHAR,    12'd0,    8'h32, 1'b0, '0},
      '{MODE_CHAR,    12'd0,    8'h37, 1'b0, '0},
      '{MODE_CHAR,    12'd0,    8'h0d, 1'b1, '{1'b0, 1'b0, 13'd0, 7'd27, STATUS_ACCEPT}},
      '{MODE_CHAR,    12'd0,    8'hff, 1'b0, '0}
   };

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_readings.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result side back-pressure in random bursts while idling is on
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 15);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic report_mismatch(string field, int unsigned got, int unsigned want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("mismatch on %s: got %0d, expected %0d (cycle %0d)", field, got, want,
                  cycle_count);
   endtask

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin : check_results
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            report_mismatch("unexpected result beat", rsp_tdata, 0);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_tdata[0] !== want.heater)
               report_mismatch("heater_on", rsp_tdata[0], want.heater);
            if (rsp_tdata[1] !== want.alarm)
               report_mismatch("alarm_on", rsp_tdata[1], want.alarm);
            if (rsp_tdata[14:2] !== want.temp_centi)
               report_mismatch("temp_centi", rsp_tdata[14:2], want.temp_centi);
            if (rsp_tdata[21:15] !== want.setpoint)
               report_mismatch("setpoint_now", rsp_tdata[21:15], want.setpoint);
            if (rsp_tdata[23:22] !== want.status)
               report_mismatch("entry_status", rsp_tdata[23:22], want.status);
         end
      end
   end

   // twice the temperature times full scale lies above level + 0.5
   function automatic bit over_band(int unsigned twice_t, int unsigned level);
      return twice_t > (2 * level + 1) * ADC_FULL;
   endfunction

   // twice the temperature times full scale lies below level - 0.5
   function automatic bit under_band(int unsigned twice_t, int unsigned level);
      return twice_t + ADC_FULL < 2 * level * ADC_FULL;
   endfunction

   // advance the thermostat state by one request beat
   function automatic reading_type predict_reading(logic [1:0] mode, logic [11:0] raw,
                                                   logic [7:0] ch);
      reading_type r;
      int unsigned s;
      int unsigned twice_t;
      int unsigned value;
      int unsigned level;
      bit          is_digit;
      r = '0;
      s = 32'(raw);
      is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      case (mode)
         MODE_SAMPLE: begin
            samples_sent++;
            twice_t = 100 * s + 50 * ADC_FULL;
            r.temp_centi = 13'(TEMP_BASE + (TEMP_SPAN * s) / ADC_FULL);
            if (over_band(twice_t, sp_deg) && heat_q)
               heat_q = 1'b0;
            else if (under_band(twice_t, sp_deg) && !heat_q)
               heat_q = 1'b1;
            if (over_band(twice_t, alarm_lvl) && !alarm_q)
               alarm_q = 1'b1;
            else if (under_band(twice_t, alarm_lvl) && alarm_q)
               alarm_q = 1'b0;
         end
         MODE_CHAR: begin
            chars_sent++;
            if (!hi_valid) begin
               if (is_digit) begin
                  dig_hi = 32'(ch - CHAR_ZERO);
                  hi_valid = 1'b1;
               end
            end else if (!lo_valid) begin
               if (is_digit) begin
                  dig_lo = 32'(ch - CHAR_ZERO);
                  lo_valid = 1'b1;
               end
            end else if (ch == CHAR_CR) begin
               value = dig_hi * 10 + dig_lo;
               if (value >= 32'(cfg_min) && value <= 32'(cfg_max)) begin
                  level = value + 32'(cfg_off);
                  if (level > 32'(cfg_ceil))
                     level = 32'(cfg_ceil);
                  sp_deg = value;
                  alarm_lvl = level;
                  r.status = STATUS_ACCEPT;
                  taken_count++;
               end else begin
                  r.status = STATUS_RANGE;
                  refused_count++;
               end
            end
         end
         MODE_SESSION: begin
            hi_valid = 1'b0;
            lo_valid = 1'b0;
            dig_hi = 0;
            dig_lo = 0;
         end
         default: ;
      endcase
      r.heater = heat_q;
      r.alarm = alarm_q;
      r.setpoint = 7'(sp_deg);
      return r;
   endfunction

   // present one request beat, with an optional gap before it
   task automatic put_beat(logic [1:0] mode, logic [11:0] raw, logic [7:0] ch,
                           bit typed = 1'b0, reading_type want = '0);
      reading_type guess;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, ch, raw};
      req_tuser <= mode;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      guess = predict_reading(mode, raw, ch);
      pending_readings.push_back(typed ? want : guess);
   endtask

   // write all four registers once the block has drained
   task automatic load_settings(logic [6:0] lo, logic [6:0] hi, logic [6:0] off,
                                logic [6:0] ceil);
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= CSR_SP_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      csr_addr <= CSR_SP_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      csr_addr <= CSR_ALARM_OFFSET;
      csr_wdata <= off;
      @(posedge clock);
      csr_addr <= CSR_ALARM_CEILING;
      csr_wdata <= ceil;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_min = lo;
      cfg_max = hi;
      cfg_off = off;
      cfg_ceil = ceil;
      settings_used++;
   endtask

   // any byte that is not a digit
   function automatic logic [7:0] noise_char();
      return $urandom_range(0, 1) ? 8'($urandom_range(0, 47)) : 8'($urandom_range(58, 255));
   endfunction

   // converter code near a given temperature in whole degrees
   function automatic logic [11:0] raw_near(int unsigned deg);
      int c;
      c = ((int'(deg) - 25) * 4095) / 50 + int'($urandom_range(0, 120)) - 60;
      if (c < 0)
         c = 0;
      if (c > 4095)
         c = 4095;
      return c[11:0];
   endfunction

   // random converter code and random byte
   function automatic logic [11:0] any_raw();
      return 12'($urandom_range(0, 4095));
   endfunction

   function automatic logic [7:0] any_char();
      return 8'($urandom_range(0, 255));
   endfunction

   // one well-formed entry of value v with random noise around it
   task automatic send_entry(int v, bit fresh);
      if (fresh)
         put_beat(MODE_SESSION, any_raw(), any_char());
      repeat ($urandom_range(0, 2))
         put_beat(MODE_CHAR, any_raw(), noise_char());
      put_beat(MODE_CHAR, any_raw(), 8'(CHAR_ZERO + v / 10));
      if ($urandom_range(0, 3) == 0)
         put_beat(MODE_CHAR, any_raw(), noise_char());
      put_beat(MODE_CHAR, any_raw(), 8'(CHAR_ZERO + v % 10));
      put_beat(MODE_CHAR, any_raw(), CHAR_CR);
      if ($urandom_range(0, 3) == 0)
         put_beat(MODE_CHAR, any_raw(), CHAR_CR);
      if ($urandom_range(0, 3) == 0)
         put_beat(MODE_CHAR, any_raw(), any_char());
   endtask

   // random mix of entries, samples near the bands and noise
   task automatic random_phase(int unsigned target);
      int unsigned done;
      int          v;
      done = 0;
      while (done < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               if ($urandom_range(0, 1)) begin
                  v = int'($urandom_range(0, 99));
               end else begin
                  v = ($urandom_range(0, 1) ? int'(cfg_min) : int'(cfg_max))
                      + int'($urandom_range(0, 2)) - 1;
                  if (v < 0)
                     v = 0;
                  if (v > 99)
                     v = 99;
               end
               send_entry(v, $urandom_range(0, 5) != 0);
               done += 6;
            end
            4, 5, 6, 7: begin
               case ($urandom_range(0, 2))
                  0: put_beat(MODE_SAMPLE, raw_near(sp_deg), any_char());
                  1: put_beat(MODE_SAMPLE, raw_near(alarm_lvl), any_char());
                  default: put_beat(MODE_SAMPLE, any_raw(), any_char());
               endcase
               done++;
            end
            8: begin
               put_beat(MODE_CHAR, any_raw(), any_char());
               done++;
            end
            default: begin
               if ($urandom_range(0, 1))
                  put_beat(MODE_SESSION, any_raw(), any_char());
               else
                  put_beat(MODE_SPARE, any_raw(), any_char());
               done++;
            end
         endcase
      end
   endtask

   // main sequence
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows against reset settings
      idle_on = 1'b1;
      foreach (plan[i])
         put_beat(plan[i].mode, plan[i].raw, plan[i].ch, plan[i].typed, plan[i].want);

      // widest range, no offset, highest ceiling
      load_settings(7'd0, 7'd99, 7'd0, 7'd127);
      random_phase(85);
      // empty range: every committed value is refused
      load_settings(7'd99, 7'd0, 7'd99, 7'd0);
      random_phase(85);
      // single accepted value, no idling in this stretch
      idle_on = 1'b0;
      load_settings(7'd50, 7'd50, 7'd99, 7'd127);
      random_phase(85);
      // alarm level capped at zero
      idle_on = 1'b1;
      load_settings(7'd0, 7'd0, 7'd0, 7'd0);
      random_phase(85);
      repeat (2) begin
         load_settings(7'($urandom_range(0, 99)), 7'($urandom_range(0, 99)),
                       7'($urandom_range(0, 99)), 7'($urandom_range(0, 127)));
         random_phase(85);
      end
      idle_on = 1'b0;
      load_settings(7'($urandom_range(0, 99)), 7'($urandom_range(0, 99)),
                    7'($urandom_range(0, 99)), 7'($urandom_range(0, 127)));
      random_phase(85);
      // reset settings again, no idling to the end
      load_settings(SP_LOW_RST, SP_HIGH_RST, ALARM_OFFSET_RST, ALARM_CEILING_RST);
      random_phase(85);

      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d beats over %0d register settings: %0d samples, %0d characters",
               beats_sent, settings_used, samples_sent, chars_sent);
      $display("%0d setpoints taken, %0d entries refused, %0d mismatches",
               taken_count, refused_count, mismatches);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
